// ===== src/lfrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and constants of the lowest free room scheduler.
// ----------------------------------------------------------------------------
package lfrs_pkg;

  localparam int MAX_ROOMS = 16;
  localparam int IDX_W     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 16;
  localparam int ROOM_W    = 4;
  localparam int CFG_W     = 5;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_ROOMS_IN_USE = APB_ADDR_W'(0);
  localparam logic [CFG_W-1:0]      ROOMS_RESET       = CFG_W'(16);

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

  typedef struct packed {
    logic [TIME_W-1:0] meeting_start;
    logic [TIME_W-1:0] meeting_end;
    logic              last_meeting;
  } req_t;

  typedef struct packed {
    logic [ROOM_W-1:0] assigned_room;
    logic [TIME_W-1:0] actual_begin;
    logic [TIME_W-1:0] actual_finish;
    logic [ROOM_W-1:0] busiest_room;
    logic              report_valid;
  } rsp_t;

  // search token passed along the row of cells
  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] start;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [TIME_W-1:0] early_val;
    logic [IDX_W-1:0]  early_idx;
    logic [CNT_W-1:0]  best_cnt;
    logic [IDX_W-1:0]  best_idx;
  } tok_t;

  // update broadcast to all cells
  typedef struct packed {
    logic              we;
    logic              clr;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] finish;
  } upd_t;

endpackage

// ===== src/lfrs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_cell
// One room: holds busy-until time and use count, folds itself into the token.
// ----------------------------------------------------------------------------
module lfrs_cell import lfrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CFG_W-1:0] rooms_i,
  input  tok_t             tok_i,
  input  upd_t             upd_i,
  output tok_t             tok_o
);

  logic [TIME_W-1:0] busy_q;
  logic [CNT_W-1:0]  cnt_q;
  tok_t              tok_q, tok_d;
  logic              first, active;

  assign first  = (idx_i == '0);
  assign active = first || (32'(idx_i) < 32'(rooms_i));

  always_comb begin
    tok_d = tok_i;
    if (active && !tok_i.free_found && (busy_q <= tok_i.start)) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = idx_i;
    end
    if (active && (first || (busy_q < tok_i.early_val))) begin
      tok_d.early_val = busy_q;
      tok_d.early_idx = idx_i;
    end
    if (active && (first || (cnt_q > tok_i.best_cnt))) begin
      tok_d.best_cnt = cnt_q;
      tok_d.best_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      cnt_q  <= '0;
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (upd_i.clr) begin
        busy_q <= '0;
        cnt_q  <= '0;
      end else if (upd_i.we && (upd_i.idx == idx_i)) begin
        busy_q <= upd_i.finish;
        if (cnt_q != COUNT_MAX) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== src/lfrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_ctrl
// Request sequencer: launches scans, writes the chosen room, drives results.
// ----------------------------------------------------------------------------
module lfrs_ctrl import lfrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o,
  output tok_t launch_o,
  input  tok_t tail_i,
  output upd_t upd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WRITE,
    S_RECOUNT,
    S_COUNT,
    S_DONE
  } state_e;

  state_e            state_q;
  tok_t              launch_q;
  upd_t              upd_q;
  logic              out_valid_q;
  rsp_t              rsp_q;
  logic [TIME_W-1:0] start_q, dur_q, begin_q, finish_q;
  logic [IDX_W-1:0]  pick_q, best_q;
  logic              last_q;

  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] finish;
  logic              accept, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign sum        = {1'b0, begin_q} + {1'b0, dur_q};
  assign finish     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= '0;
      upd_q       <= '0;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
      start_q     <= '0;
      dur_q       <= '0;
      begin_q     <= '0;
      finish_q    <= '0;
      pick_q      <= '0;
      best_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // the room write goes through upd_q, so the count scan launches from the recount step after it
      launch_q.vld   <= accept || (state_q == S_RECOUNT);
      launch_q.start <= in_req_i.meeting_start;
      upd_q.we       <= (state_q == S_WRITE);
      upd_q.idx      <= pick_q;
      upd_q.finish   <= finish;
      upd_q.clr      <= (state_q == S_DONE) && out_free && last_q;
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            start_q <= in_req_i.meeting_start;
            dur_q   <= (in_req_i.meeting_end > in_req_i.meeting_start) ?
                       (in_req_i.meeting_end - in_req_i.meeting_start) : '0;
            last_q  <= in_req_i.last_meeting;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tail_i.vld) begin
            pick_q  <= tail_i.free_found ? tail_i.free_idx : tail_i.early_idx;
            begin_q <= tail_i.free_found ? start_q : tail_i.early_val;
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          finish_q <= finish;
          best_q   <= '0;
          state_q  <= last_q ? S_RECOUNT : S_DONE;
        end
        S_RECOUNT: begin
          state_q <= S_COUNT;
        end
        S_COUNT: begin
          if (tail_i.vld) begin
            best_q  <= tail_i.best_idx;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            rsp_q.assigned_room <= ROOM_W'(pick_q);
            rsp_q.actual_begin  <= begin_q;
            rsp_q.actual_finish <= finish_q;
            rsp_q.busiest_room  <= last_q ? ROOM_W'(best_q) : '0;
            rsp_q.report_valid  <= last_q;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign launch_o    = launch_q;
  assign upd_o       = upd_q;

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_i.vld |-> (state_q == S_SEARCH || state_q == S_COUNT))
    else $error("scan token reached the end outside a scan");

  a_launch_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q.vld |=> !launch_q.vld)
    else $error("scan launched twice in a row");

  a_upd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(upd_q.we && upd_q.clr))
    else $error("room write and clear together");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the done step");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_q.clr |-> (out_valid_q && rsp_q.report_valid))
    else $error("room clear without a report");

endmodule

// ===== src/lowest_free_room_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler_top
// Assigns each request to the lowest free room, or the earliest freeing one.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   request  | in_valid_i / in_ready_o | in_req_i  (req_t)
//   result   | out_valid_o/out_ready_i | out_rsp_o (rsp_t)
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata
//
// A request's search token walks the row of room cells one cell per cycle,
// then the write step writes the chosen room.
// A last request adds a use count walk along the same row.
// All room state clears at once after the report of a last request; no sweep after reset.
// A stalled result holds the block in its final step until it is taken.
// ----------------------------------------------------------------------------
module lowest_free_room_scheduler_top import lfrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  req_t                  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rsp_t                  out_rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] rooms_q;
  tok_t             tok_w [MAX_ROOMS+1];
  upd_t             upd;
  logic             cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr == ADDR_ROOMS_IN_USE);
  assign prdata  = cfg_hit ? APB_DATA_W'(rooms_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_q <= ROOMS_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      rooms_q <= pwdata[CFG_W-1:0];
    end
  end

  lfrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .launch_o    (tok_w[0]),
    .tail_i      (tok_w[MAX_ROOMS]),
    .upd_o       (upd)
  );

  for (genvar k = 0; k < MAX_ROOMS; k++) begin : g_room
    lfrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(k)),
      .rooms_i (rooms_q),
      .tok_i   (tok_w[k]),
      .upd_i   (upd),
      .tok_o   (tok_w[k+1])
    );
  end

endmodule
